// ===== rtl/pdmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdmsd_pkg
// Shared constants, tables, types and helpers of the PDM sinc decimator
// ----------------------------------------------------------------------------
package pdmsd_pkg;

    // sizes
    localparam int SINC_TAPS  = 64;
    localparam int FIR_TAPS   = 39;
    localparam int COEF_WIDTH = 16;
    localparam int NUM_COEF   = 39;
    localparam int FRAC       = COEF_WIDTH - 1;

    localparam int PCM_W      = 12;
    localparam int PCM_MAX    = 4095;
    localparam int SUM_W      = 17;                  // largest window sum is 68018
    localparam int DEC_W      = SUM_W - 4;
    localparam int SINC_CNT_W = $clog2(SINC_TAPS);
    localparam int CIDX_W     = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
    localparam int PROD_W     = COEF_WIDTH + PCM_W + 1;
    localparam int ACC_W      = PROD_W + CIDX_W + 1;

    typedef logic [PCM_W-1:0] pcm_t;

    // sinc window, symmetric and non-negative
    localparam logic [11:0] WIN_TAB [64] = '{
        12'd0,    12'd2,    12'd9,    12'd21,   12'd39,   12'd63,   12'd94,   12'd132,
        12'd179,  12'd236,  12'd302,  12'd379,  12'd467,  12'd565,  12'd674,  12'd792,
        12'd920,  12'd1055, 12'd1196, 12'd1341, 12'd1487, 12'd1633, 12'd1776, 12'd1913,
        12'd2042, 12'd2159, 12'd2263, 12'd2352, 12'd2422, 12'd2474, 12'd2506, 12'd2516,
        12'd2516, 12'd2506, 12'd2474, 12'd2422, 12'd2352, 12'd2263, 12'd2159, 12'd2042,
        12'd1913, 12'd1776, 12'd1633, 12'd1487, 12'd1341, 12'd1196, 12'd1055, 12'd920,
        12'd792,  12'd674,  12'd565,  12'd467,  12'd379,  12'd302,  12'd236,  12'd179,
        12'd132,  12'd94,   12'd63,   12'd39,   12'd21,   12'd9,    12'd2,    12'd0
    };

    // low-pass coefficients in Q1.15
    localparam int LP_Q15 [NUM_COEF] = '{
        214, 121, 90, -5, -172, -405, -676, -942, -1145, -1221,
        -1112, -780, -215, 558, 1478, 2454, 3376, 4134, 4631, 4805,
        4631, 4134, 3376, 2454, 1478, 558, -215, -780, -1112, -1221,
        -1145, -942, -676, -405, -172, -5, 90, 121, 214
    };

    // controller states
    typedef enum logic [1:0] {
        T_IDLE,
        T_SINC,
        T_FIR,
        T_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAC,
        F_DRAIN,
        F_ROUND
    } fir_state_t;

    // sinc stage result
    typedef struct packed {
        logic done;
        pcm_t dec;
        logic clip;
    } sinc_res_t;

    // fir request and result
    typedef struct packed {
        logic start;
        logic en;
        pcm_t dec;
    } fir_req_t;

    typedef struct packed {
        logic done;
        pcm_t sample;
        logic clip;
    } fir_res_t;

    // window entry k
    function automatic logic [11:0] win_at(input logic [5:0] k);
        return WIN_TAB[k];
    endfunction

    // coefficient j with FRAC fraction bits, zero beyond the defined taps
    function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [5:0] j);
        int q;
        int s;
        int r;
        r = 0;
        if (int'(j) < NUM_COEF) begin
            q = LP_Q15[j];
            s = 15 - FRAC;
            if (s <= 0) begin
                r = q <<< (-s);
            end else begin
                r = (q + (1 <<< (s - 1))) >>> s;
            end
        end
        return COEF_WIDTH'(r);
    endfunction

endpackage

// ===== rtl/pdmsd_sinc.sv =====
// ----------------------------------------------------------------------------
// pdmsd_sinc
// Bit-serial sinc window accumulator with divide by 16 and saturation
// ----------------------------------------------------------------------------
module pdmsd_sinc
    import pdmsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SINC_TAPS-1:0] bits,
    output sinc_res_t            res
);

    logic [SINC_TAPS-1:0]  bits_reg, bits_next;
    logic [SINC_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [SUM_W-1:0]      sum_reg,  sum_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DEC_W-1:0]      quot;

    // one window entry per cycle, lowest bit first
    always_comb begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bits_next = bits;
            cnt_next  = '0;
            sum_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (bits_reg[0]) begin
                sum_next = sum_reg + SUM_W'(win_at(6'(cnt_reg)));
            end
            bits_next = bits_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == SINC_CNT_W'(SINC_TAPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bits_reg <= bits_next;
        cnt_reg  <= cnt_next;
        sum_reg  <= sum_next;
    end

    // truncating divide by 16, then clamp to the pcm range
    assign quot = sum_reg[SUM_W-1:4];

    always_comb begin
        res.done = done_reg;
        if (quot > DEC_W'(PCM_MAX)) begin
            res.dec  = pcm_t'(PCM_MAX);
            res.clip = 1'b1;
        end else begin
            res.dec  = quot[PCM_W-1:0];
            res.clip = 1'b0;
        end
    end

endmodule

// ===== rtl/pdmsd_cell.sv =====
// ----------------------------------------------------------------------------
// pdmsd_cell
// One sample slot of the fir delay chain
// ----------------------------------------------------------------------------
module pdmsd_cell
    import pdmsd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  pcm_t d,
    output pcm_t q
);

    pcm_t q_reg;

    // delay line starts cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (load) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/pdmsd_fir.sv =====
// ----------------------------------------------------------------------------
// pdmsd_fir
// Chain of sample cells rotated past one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
module pdmsd_fir
    import pdmsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fir_req_t req,
    output fir_res_t res
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);

    fir_state_t                 state_reg, state_next;
    logic [CIDX_W-1:0]          cidx_reg,  cidx_next;
    logic signed [PROD_W-1:0]   prod_reg,  prod_next;
    logic                       pvld_reg,  pvld_next;
    logic signed [ACC_W-1:0]    acc_reg,   acc_next;
    logic                       done_reg,  done_next;
    pcm_t                       smp_reg,   smp_next;
    logic                       clip_reg,  clip_next;

    pcm_t                       x [FIR_TAPS];
    pcm_t                       head_d;
    logic                       chain_load;
    logic signed [ACC_W-1:0]    rnd;
    logic [ACC_W-FRAC-1:0]      q;

    // cell 0 takes the new sample on a shift and the last cell on a rotate
    assign head_d = (state_reg == F_IDLE) ? req.dec : x[FIR_TAPS-1];

    pdmsd_cell u_cell_0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (chain_load),
        .d       (head_d),
        .q       (x[0])
    );

    for (genvar g = 1; g < FIR_TAPS; g++) begin : g_chain
        pdmsd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load    (chain_load),
            .d       (x[g-1]),
            .q       (x[g])
        );
    end

    // rounding of the accumulated sum, clamped in the round state
    assign rnd = acc_reg + HALF;
    assign q   = rnd[ACC_W-1:FRAC];

    // sequencer and mac
    always_comb begin
        state_next = state_reg;
        cidx_next  = cidx_reg;
        prod_next  = prod_reg;
        pvld_next  = 1'b0;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        smp_next   = smp_reg;
        clip_next  = clip_reg;
        chain_load = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    chain_load = 1'b1;
                    cidx_next  = CIDX_W'(FIR_TAPS - 1);
                    acc_next   = '0;
                    if (req.en) begin
                        state_next = F_MAC;
                    end else begin
                        done_next = 1'b1;
                    end
                end
            end
            F_MAC: begin
                chain_load = 1'b1;
                prod_next  = PROD_W'(coef_at(6'(cidx_reg)) * $signed({1'b0, x[FIR_TAPS-1]}));
                pvld_next  = 1'b1;
                if (pvld_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                cidx_next = cidx_reg - 1'b1;
                if (cidx_reg == '0) begin
                    state_next = F_DRAIN;
                end
            end
            F_DRAIN: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = F_ROUND;
            end
            F_ROUND: begin
                if (rnd < 0) begin
                    smp_next  = '0;
                    clip_next = 1'b1;
                end else if (q > (ACC_W - FRAC)'(PCM_MAX)) begin
                    smp_next  = pcm_t'(PCM_MAX);
                    clip_next = 1'b1;
                end else begin
                    smp_next  = q[PCM_W-1:0];
                    clip_next = 1'b0;
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pvld_reg  <= pvld_next;
            done_reg  <= done_next;
        end
        cidx_reg <= cidx_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        smp_reg  <= smp_next;
        clip_reg <= clip_next;
    end

    assign res.done   = done_reg;
    assign res.sample = smp_reg;
    assign res.clip   = clip_reg;

endmodule

// ===== rtl/pdm_sinc_decimator_with_fir_core.sv =====
// ----------------------------------------------------------------------------
// pdm_sinc_decimator_with_fir_core
// PDM to PCM decimator: sinc window sum, divide by 16, optional 39-tap FIR
// ----------------------------------------------------------------------------
// One transaction carries 64 PDM bits and yields one 12-bit PCM sample. The
// sinc stage adds one window entry per cycle; with the low-pass enable set
// the sample then rotates once through the 39-cell delay chain past a single
// multiplier, followed by the product register, a drain step, rounding and
// handover to the output register. The delay line takes in every decimated
// sample, filtered or not, and is cleared by reset. The next transaction is
// taken once the previous result sits in the output register, so the input
// takes no new item while one is still in flight.
// ----------------------------------------------------------------------------
module pdm_sinc_decimator_with_fir_core
    import pdmsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_pdm_bits,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pcm_sample,
    output logic        m_clipped
);

    top_state_t state_reg, state_next;
    logic       lp_en_reg;
    logic       m_valid_reg, m_valid_next;
    pcm_t       m_sample_reg, m_sample_next;
    logic       m_clip_reg,   m_clip_next;

    logic       sinc_start;
    sinc_res_t  sinc_res;
    fir_req_t   fir_req;
    fir_res_t   fir_res;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            lp_en_reg <= cfg_wr_data;
        end
    end

    pdmsd_sinc u_sinc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sinc_start),
        .bits    (s_pdm_bits[SINC_TAPS-1:0]),
        .res     (sinc_res)
    );

    pdmsd_fir u_fir (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fir_req),
        .res     (fir_res)
    );

    // transaction sequencing and output register
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        m_clip_next   = m_clip_reg;
        s_ready       = 1'b0;
        sinc_start    = 1'b0;
        fir_req.start = 1'b0;
        fir_req.en    = lp_en_reg;
        fir_req.dec   = sinc_res.dec;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sinc_start = 1'b1;
                    state_next = T_SINC;
                end
            end
            T_SINC: begin
                if (sinc_res.done) begin
                    fir_req.start = 1'b1;
                    state_next    = T_FIR;
                end
            end
            T_FIR: begin
                if (fir_res.done) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = lp_en_reg ? fir_res.sample : sinc_res.dec;
                    m_clip_next   = sinc_res.clip | (lp_en_reg & fir_res.clip);
                    state_next    = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_sample_reg <= m_sample_next;
        m_clip_reg   <= m_clip_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pcm_sample = m_sample_reg;
    assign m_clipped    = m_clip_reg;

endmodule

// ===== rtl/pdmsd_checker.sv =====
// ----------------------------------------------------------------------------
// pdmsd_checker
// Port-level checks on the decimator, bound to the top level
// ----------------------------------------------------------------------------
module pdmsd_checker
    import pdmsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_pcm_sample,
    input logic        m_clipped
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pcm_sample) && $stable(m_clipped))
        else $error("result changed while stalled");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one transaction at a time: the window sum keeps the input closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened too early");

    // a new result only appears when the input was closed just before
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a transaction in flight");

endmodule

bind pdm_sinc_decimator_with_fir_core pdmsd_checker u_pdmsd_checker (.*);
